// ===== hdl/bchd_pkg.sv =====
// ============================================================================
// bchd_pkg
// Shared types and constants for the button click and hold detector.
// ============================================================================
package bchd_pkg;

  localparam int CFG_W    = 16;
  localparam int BUTTON_W = 8;
  localparam int CODE_W   = 3;
  localparam int APB_AW   = 4;
  localparam int APB_DW   = 32;

  typedef enum logic [CODE_W-1:0] {
    EV_DOWN    = 3'd0,
    EV_UP      = 3'd1,
    EV_CLICKED = 3'd2,
    EV_DOUBLE  = 3'd3,
    EV_HELD    = 3'd4
  } event_code_t;

  typedef enum logic [1:0] {
    REG_BOUNCE = 2'd0,
    REG_HOLD   = 2'd1,
    REG_CLICK  = 2'd2,
    REG_BUTTON = 2'd3
  } reg_index_t;

  localparam logic [CFG_W-1:0]    BOUNCE_RESET = 16'd20;
  localparam logic [CFG_W-1:0]    HOLD_RESET   = 16'd1000;
  localparam logic [CFG_W-1:0]    CLICK_RESET  = 16'd300;
  localparam logic [BUTTON_W-1:0] BUTTON_RESET = 8'd0;

  // Control of one countdown timer for one processed tick.
  typedef struct packed {
    logic step;   // a tick is processed this cycle
    logic start;  // load the timer
    logic stop;   // cancel the timer
    logic count;  // count down if running
  } timer_ctl_t;

  typedef struct packed {
    logic running;
    logic expire;  // expires on the tick being processed
  } timer_stat_t;

endpackage

// ===== hdl/bchd_tick_if.sv =====
// ============================================================================
// bchd_tick_if
// Tick channel: one raw pin sample per request.
// ============================================================================
interface bchd_tick_if;
  logic valid;
  logic ready;
  logic pressed_level;

  modport source (output valid, output pressed_level, input ready);
  modport sink (input valid, input pressed_level, output ready);
endinterface

// ===== hdl/bchd_event_if.sv =====
// ============================================================================
// bchd_event_if
// Event channel: one button event per request.
// ============================================================================
interface bchd_event_if;
  import bchd_pkg::*;

  logic                valid;
  logic                ready;
  logic [CODE_W-1:0]   event_code;
  logic [BUTTON_W-1:0] event_button;
  logic                last_event;

  modport source (output valid, output event_code, output event_button,
                  output last_event, input ready);
  modport sink (input valid, input event_code, input event_button,
                input last_event, output ready);
endinterface

// ===== hdl/button_click_hold_detector.sv =====
// ============================================================================
// button_click_hold_detector
// Debounces a button sampled once per tick and reports down, up, clicked,
// double clicked and held events.
// ============================================================================
//
//   Channel  Direction  Payload                                 Per request
//   tick     in         pressed_level                           one tick
//   evt      out        event_code, event_button, last_event    one event
//   apb      in         bounce, hold, click, button registers   one write
//
// A tick is registered on entry and processed once the event register can take
// its events (zero, one or two), which are then loaded into the event register.
// One tick per cycle is accepted; a tick that yields two events presents them
// one after the other, and the input stalls only while events wait to be taken.
// Synchronous reset clears all timers and state; the button reads released.
//
module button_click_hold_detector #(
  parameter int TIMER_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  bchd_tick_if.sink                   tick,
  bchd_event_if.source                evt,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bchd_pkg::APB_AW-1:0] paddr,
  input  logic [bchd_pkg::APB_DW-1:0] pwdata,
  output logic [bchd_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import bchd_pkg::*;

  // Configuration registers
  logic [CFG_W-1:0]    bounce_ticks;
  logic [CFG_W-1:0]    hold_ticks;
  logic [CFG_W-1:0]    click_ticks;
  logic [BUTTON_W-1:0] button_number;
  reg_index_t          reg_sel;
  logic                cfg_write;

  assign pready    = 1'b1;
  assign reg_sel   = reg_index_t'(paddr[APB_AW-1:2]);
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      bounce_ticks  <= BOUNCE_RESET;
      hold_ticks    <= HOLD_RESET;
      click_ticks   <= CLICK_RESET;
      button_number <= BUTTON_RESET;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_BOUNCE: bounce_ticks  <= pwdata[CFG_W-1:0];
        REG_HOLD:   hold_ticks    <= pwdata[CFG_W-1:0];
        REG_CLICK:  click_ticks   <= pwdata[CFG_W-1:0];
        REG_BUTTON: button_number <= pwdata[BUTTON_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_BOUNCE: prdata = APB_DW'(bounce_ticks);
      REG_HOLD:   prdata = APB_DW'(hold_ticks);
      REG_CLICK:  prdata = APB_DW'(click_ticks);
      REG_BUTTON: prdata = APB_DW'(button_number);
      default:    prdata = '0;
    endcase
  end

  // Input register
  logic in_valid;
  logic level;
  logic go;

  // Event register, up to two pending events
  logic [1:0]  ev_count;
  event_code_t ev0_code;
  logic        ev0_last;
  event_code_t ev1_code;
  logic        ev1_last;
  logic        pop;

  assign pop   = evt.valid && evt.ready;
  assign go    = in_valid && ((ev_count == 2'd0) || (ev_count == 2'd1 && pop));
  assign tick.ready = !in_valid || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (tick.valid && tick.ready) begin
      in_valid <= 1'b1;
    end else if (go) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      level <= tick.pressed_level;
    end
  end

  // Button state
  logic        raw_previous;
  logic        stable_pressed;
  timer_ctl_t  db_ctl, hold_ctl, click_ctl;
  timer_stat_t db_stat, hold_stat, click_stat;
  logic        change;
  logic        down;
  logic        up;
  logic        dbl;
  logic        held;
  logic        clicked;
  logic [1:0]  n_events;
  event_code_t first_code;
  event_code_t second_code;

  assign change  = db_stat.expire && (level != stable_pressed);
  assign down    = change && level;
  assign up      = change && !level;
  assign dbl     = up && hold_stat.running && click_stat.running;
  assign held    = hold_stat.expire;
  assign clicked = click_stat.expire;

  always_comb begin
    db_ctl.step  = go;
    // A raw edge restarts the debounce timer only once the previous one is done.
    db_ctl.start = (level != raw_previous) && (!db_stat.running || db_stat.expire);
    db_ctl.stop  = 1'b0;
    db_ctl.count = 1'b1;

    hold_ctl.step  = go;
    hold_ctl.start = down;
    hold_ctl.stop  = up;
    hold_ctl.count = !change;

    click_ctl.step  = go;
    click_ctl.start = up && hold_stat.running && !click_stat.running;
    click_ctl.stop  = dbl || held;
    click_ctl.count = 1'b1;
  end

  bchd_timer #(.TIMER_BITS(TIMER_BITS)) u_db_timer (
    .clk  (clk),
    .rst  (rst),
    .ctl  (db_ctl),
    .load (bounce_ticks),
    .stat (db_stat)
  );

  bchd_timer #(.TIMER_BITS(TIMER_BITS)) u_hold_timer (
    .clk  (clk),
    .rst  (rst),
    .ctl  (hold_ctl),
    .load (hold_ticks),
    .stat (hold_stat)
  );

  bchd_timer #(.TIMER_BITS(TIMER_BITS)) u_click_timer (
    .clk  (clk),
    .rst  (rst),
    .ctl  (click_ctl),
    .load (click_ticks),
    .stat (click_stat)
  );

  always_comb begin
    n_events = 2'(change) + 2'(dbl) + 2'(held) + 2'(clicked);
    priority if (down) begin
      first_code = EV_DOWN;
    end else if (up) begin
      first_code = EV_UP;
    end else if (held) begin
      first_code = EV_HELD;
    end else begin
      first_code = EV_CLICKED;
    end
    second_code = dbl ? EV_DOUBLE : EV_CLICKED;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_previous   <= 1'b0;
      stable_pressed <= 1'b0;
    end else if (go) begin
      raw_previous <= level;
      if (change) begin
        stable_pressed <= level;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_count <= 2'd0;
    end else if (go) begin
      ev_count <= n_events;
    end else if (pop) begin
      ev_count <= ev_count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      ev0_code <= first_code;
      ev0_last <= (n_events == 2'd1);
      ev1_code <= second_code;
      ev1_last <= 1'b1;
    end else if (pop) begin
      ev0_code <= ev1_code;
      ev0_last <= ev1_last;
    end
  end

  assign evt.valid        = (ev_count != 2'd0);
  assign evt.event_code   = ev0_code;
  assign evt.event_button = button_number;
  assign evt.last_event   = ev0_last;

endmodule

// ===== hdl/bchd_timer.sv =====
// ============================================================================
// bchd_timer
// Countdown timer with saturating load; a load of zero expires after one tick.
// ============================================================================
module bchd_timer #(
  parameter int TIMER_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  bchd_pkg::timer_ctl_t       ctl,
  input  logic [bchd_pkg::CFG_W-1:0] load,
  output bchd_pkg::timer_stat_t      stat
);
  import bchd_pkg::*;

  logic [TIMER_BITS-1:0] remaining;
  logic [TIMER_BITS-1:0] remaining_next;
  logic                  running;
  logic                  running_next;
  logic [TIMER_BITS-1:0] load_sat;
  logic                  at_end;

  generate
    if (TIMER_BITS >= CFG_W) begin : g_wide
      assign load_sat = TIMER_BITS'(load);
    end else begin : g_narrow
      assign load_sat = (|load[CFG_W-1:TIMER_BITS]) ? '1 : load[TIMER_BITS-1:0];
    end
  endgenerate

  assign at_end = (remaining <= TIMER_BITS'(1));

  // A restart in the same tick does not hide the expiry; the load still wins.
  assign stat.running = running;
  assign stat.expire  = running && ctl.count && at_end && !ctl.stop;

  always_comb begin
    remaining_next = remaining;
    running_next   = running;
    if (ctl.step) begin
      if (ctl.start) begin
        remaining_next = load_sat;
        running_next   = 1'b1;
      end else if (ctl.stop) begin
        remaining_next = '0;
        running_next   = 1'b0;
      end else if (running && ctl.count) begin
        if (at_end) begin
          remaining_next = '0;
          running_next   = 1'b0;
        end else begin
          remaining_next = remaining - TIMER_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
      running   <= 1'b0;
    end else begin
      remaining <= remaining_next;
      running   <= running_next;
    end
  end

endmodule

// ===== sim/button_click_hold_detector_tb.sv =====
// ============================================================================
// button_click_hold_detector_tb
// Self-checking bench for the button detector. Ticks go in over the tick
// channel, and a scoreboard predicts the down, up, clicked, double clicked
// and held events. Every event taken from the event channel is compared with
// the prediction. The register settings change between phases, and both
// sides of the block are stalled at random.
// ============================================================================
module button_click_hold_detector_tb;
  import bchd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_PHASES = 6;
  localparam int TICKS_PER_PHASE = 150;

  typedef struct {
    event_code_t         code;
    logic [BUTTON_W-1:0] button;
    logic                last;
  } button_event_t;

  // Predicts the events of each tick and holds them until they come out.
  class event_scoreboard;
    logic [CFG_W-1:0]    bounce_ticks;
    logic [CFG_W-1:0]    hold_ticks;
    logic [CFG_W-1:0]    click_ticks;
    logic [BUTTON_W-1:0] button_id;
    bit                  raw_prev;
    bit                  stable;
    logic [CFG_W-1:0]    deb_left;
    logic [CFG_W-1:0]    hold_left;
    logic [CFG_W-1:0]    click_left;
    bit                  deb_on;
    bit                  hold_on;
    bit                  click_on;
    button_event_t       waiting[$];
    int                  events_checked;
    int                  mismatches;

    function new();
      bounce_ticks = BOUNCE_RESET;
      hold_ticks = HOLD_RESET;
      click_ticks = CLICK_RESET;
      button_id = BUTTON_RESET;
      raw_prev = 0;
      stable = 0;
      deb_left = '0;
      hold_left = '0;
      click_left = '0;
      deb_on = 0;
      hold_on = 0;
      click_on = 0;
      events_checked = 0;
      mismatches = 0;
    endfunction

    function void write_reg(reg_index_t idx, logic [APB_DW-1:0] value);
      case (idx)
        REG_BOUNCE: bounce_ticks = value[CFG_W-1:0];
        REG_HOLD:   hold_ticks = value[CFG_W-1:0];
        REG_CLICK:  click_ticks = value[CFG_W-1:0];
        REG_BUTTON: button_id = value[BUTTON_W-1:0];
        default: ;
      endcase
    endfunction

    // A load of zero or one runs out on the next tick.
    function bit count_down(inout logic [CFG_W-1:0] left, inout bit on);
      if (left <= 1) begin
        left = '0;
        on = 0;
        return 1;
      end
      left = left - 1'b1;
      return 0;
    endfunction

    function void note_tick(bit lvl);
      event_code_t   codes[2];
      int            n;
      bit            hold_fresh;
      bit            click_fresh;
      button_event_t ev;
      n = 0;
      hold_fresh = 0;
      click_fresh = 0;
      if (deb_on) begin
        if (count_down(deb_left, deb_on) && lvl != stable) begin
          stable = lvl;
          if (lvl) begin
            codes[n] = EV_DOWN;
            n++;
            hold_left = hold_ticks;
            hold_on = 1;
            hold_fresh = 1;
          end else begin
            codes[n] = EV_UP;
            n++;
            // A release after a hold report starts no click window.
            if (hold_on) begin
              if (click_on) begin
                click_on = 0;
                click_left = '0;
                codes[n] = EV_DOUBLE;
                n++;
              end else begin
                click_left = click_ticks;
                click_on = 1;
                click_fresh = 1;
              end
            end
            hold_on = 0;
            hold_left = '0;
          end
        end
      end
      if (lvl != raw_prev && !deb_on) begin
        deb_left = bounce_ticks;
        deb_on = 1;
      end
      raw_prev = lvl;
      if (hold_on && !hold_fresh && n < 2) begin
        if (count_down(hold_left, hold_on)) begin
          codes[n] = EV_HELD;
          n++;
          click_on = 0;
          click_left = '0;
        end
      end
      if (click_on && !click_fresh && n < 2) begin
        if (count_down(click_left, click_on)) begin
          codes[n] = EV_CLICKED;
          n++;
        end
      end
      for (int k = 0; k < n; k++) begin
        ev.code = codes[k];
        ev.button = button_id;
        ev.last = (k == n - 1);
        waiting.push_back(ev);
      end
    endfunction

    function void check_event(logic [CODE_W-1:0] code, logic [BUTTON_W-1:0] button,
                              logic last);
      button_event_t ev;
      events_checked++;
      if (waiting.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected event: code %0d button %0d last %0d", code, button, last);
        return;
      end
      ev = waiting.pop_front();
      if (code !== ev.code || button !== ev.button || last !== ev.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("event mismatch: expected code %0d button %0d last %0d, got %0d %0d %0d",
                   ev.code, ev.button, ev.last, code, button, last);
      end
    endfunction

    function int pending();
      return waiting.size();
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  bchd_tick_if  tick_bus ();
  bchd_event_if evt_bus ();

  button_click_hold_detector dut (
    .clk     (clk),
    .rst     (rst),
    .tick    (tick_bus),
    .evt     (evt_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  event_scoreboard sb = new();
  int  cycles = 0;
  int  ticks_sent = 0;
  int  send_idle_pct = 10;
  int  recv_idle_pct = 72;
  bit  gen_level = 0;
  int  run_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  // Event side: take what is offered, then pick the next ready at random.
  always @(posedge clk) begin
    if (!rst && evt_bus.valid && evt_bus.ready)
      sb.check_event(evt_bus.event_code, evt_bus.event_button, evt_bus.last_event);
    evt_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic configure(input logic [CFG_W-1:0] bounce, input logic [CFG_W-1:0] hold,
                           input logic [CFG_W-1:0] click, input logic [BUTTON_W-1:0] button);
    logic [APB_DW-1:0] values[4];
    reg_index_t        idx;
    // Upper bits carry junk; the registers keep only their own width.
    values[0] = {16'($urandom), bounce};
    values[1] = {16'($urandom), hold};
    values[2] = {16'($urandom), click};
    values[3] = {24'($urandom), button};
    for (int i = 0; i < 4; i++) begin
      idx = reg_index_t'(i);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= {idx, 2'b00};
      pwdata <= values[i];
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      sb.write_reg(idx, values[i]);
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_tick(input bit lvl);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 20) gap++;
    if (gap > 0) begin
      tick_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick_bus.valid <= 1'b1;
    tick_bus.pressed_level <= lvl;
    do @(posedge clk); while (!tick_bus.ready);
    sb.note_tick(lvl);
    ticks_sent++;
  endtask

  // Let every predicted event drain, plus the cycles a silent tick needs.
  task automatic settle();
    tick_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Mostly presses and releases sized around the current timers, with some
  // random chatter on top.
  function automatic bit next_level();
    int b;
    if ($urandom_range(99) < 15) return bit'($urandom_range(1));
    if (run_left == 0) begin
      b = (sb.bounce_ticks == 0) ? 1 : int'(sb.bounce_ticks);
      gen_level = ~gen_level;
      case ($urandom_range(2))
        0: run_left = $urandom_range(1, b + 2);
        1: run_left = gen_level ? $urandom_range(b + 1, b + int'(sb.hold_ticks))
                                : $urandom_range(b + 1, b + int'(sb.click_ticks));
        default: run_left = gen_level ? $urandom_range(int'(sb.hold_ticks),
                                                       int'(sb.hold_ticks) + b + 5)
                                      : $urandom_range(1, int'(sb.click_ticks) + b + 4);
      endcase
    end
    run_left--;
    return gen_level;
  endfunction

  initial begin
    logic [27:0] directed;
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    tick_bus.valid <= 1'b0;
    tick_bus.pressed_level <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Single click, double click, hold then release, and a glitch that
    // settles back before the debounce runs out.
    configure(16'd1, 16'd4, 16'd3, 8'hA5);
    directed = 28'b1100000_110011000_111111100_100;
    for (int i = 27; i >= 0; i--) send_tick(directed[i]);
    settle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      send_idle_pct = (p < 2) ? 10 : (p < 4) ? 72 : 0;
      recv_idle_pct = (p < 2) ? 72 : (p < 4) ? 10 : 0;
      // Zero timer registers behave as one tick.
      if (p == 0) configure(16'd0, 16'd0, 16'd0, 8'hFF);
      else if (p == 3) configure(16'd0, 16'd6, 16'd4, 8'h00);
      else configure(16'($urandom_range(0, 4)), 16'($urandom_range(2, 25)),
                     16'($urandom_range(2, 20)), 8'($urandom_range(0, 255)));
      run_left = 0;
      for (int i = 0; i < TICKS_PER_PHASE; i++) send_tick(next_level());
      settle();
    end

    // Largest hold and click loads: two quick clicks give a double click.
    send_idle_pct = 10;
    recv_idle_pct = 10;
    configure(16'd1, 16'hFFFF, 16'hFFFF, 8'h00);
    repeat (2) begin
      repeat (3) send_tick(1'b1);
      repeat (3) send_tick(1'b0);
    end
    settle();
    // Largest debounce load: later edges are ignored while it runs.
    configure(16'hFFFF, 16'd1, 16'd1, 8'h5A);
    for (int i = 0; i < 12; i++) send_tick(bit'(i % 3 == 0));
    settle();
    repeat (8) @(posedge clk);

    $display("%0d ticks sent over %0d register settings, %0d events checked",
             ticks_sent, RANDOM_PHASES + 3, sb.events_checked);
    $display("%0d mismatches, %0d events never seen", sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
